FILE: design/lld_pkg.sv
// ----------------------------------------------------------------------------
// lld_pkg - shared types and constants of the least-loaded job dispatcher
// Field widths, defaults, action codes and the result record.
// ----------------------------------------------------------------------------
package lld_pkg;

  localparam int NUM_SERVERS_DEF = 16;
  localparam int TIME_BITS_DEF   = 40;

  localparam int SRV_W   = 4;   // server index field
  localparam int UNIT_W  = 8;   // unit time and job units fields
  localparam int OUT_T_W = 40;  // finish time and makespan fields
  localparam int ACT_W   = 5;   // active_servers register
  localparam int PROD_W  = 2 * UNIT_W;

  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  localparam logic ACTION_SET_RATE = 1'b0;
  localparam logic ACTION_ASSIGN   = 1'b1;

  typedef struct packed {
    logic               saturated;
    logic [OUT_T_W-1:0] makespan;
    logic [OUT_T_W-1:0] finish_time;
    logic [SRV_W-1:0]   chosen_server;
  } lld_result_t;

endpackage

FILE: design/lld_ram.sv
// ----------------------------------------------------------------------------
// lld_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module lld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lld_ctrl.sv
// ----------------------------------------------------------------------------
// lld_ctrl - sequencer and datapath of the dispatcher
// Clears both tables after reset, writes rates, and for an assign scans the
// busy times through one shared compare, then multiplies, adds and writes back.
// ----------------------------------------------------------------------------
module lld_ctrl #(
  parameter int NUM_SERVERS = 16,
  parameter int TIME_BITS   = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [lld_pkg::SRV_W-1:0]           in_server,
  input  logic [lld_pkg::UNIT_W-1:0]          in_unit,
  input  logic [lld_pkg::UNIT_W-1:0]          in_units,
  input  logic [$clog2(NUM_SERVERS+1)-1:0]    live,
  input  logic                                res_ready,
  output logic                                res_valid,
  output lld_pkg::lld_result_t                res
);
  import lld_pkg::*;

  localparam int SIDX_W = NUM_SERVERS > 1 ? $clog2(NUM_SERVERS) : 1;
  localparam int CNT_W  = $clog2(NUM_SERVERS + 1);
  localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(NUM_SERVERS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_RATE  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_ADD   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]           state;
  logic [SIDX_W-1:0]    clr_cnt;
  logic [CNT_W-1:0]     iss;
  logic [SIDX_W-1:0]    cmp_idx;
  logic [SIDX_W-1:0]    best;
  logic [TIME_BITS-1:0] best_val;
  logic [UNIT_W-1:0]    units;
  logic [PROD_W-1:0]    prod;
  logic [TIME_BITS-1:0] sum;
  logic                 sat;
  logic [TIME_BITS-1:0] max_busy;
  logic [TIME_BITS-1:0] max_busy_next;
  logic [TIME_BITS:0]   sum_wide;

  logic                 busy_we;
  logic [SIDX_W-1:0]    busy_waddr;
  logic [TIME_BITS-1:0] busy_wdata;
  logic [SIDX_W-1:0]    busy_raddr;
  logic [TIME_BITS-1:0] busy_rdata;
  logic                 rate_we;
  logic [SIDX_W-1:0]    rate_waddr;
  logic [UNIT_W-1:0]    rate_wdata;
  logic [UNIT_W-1:0]    rate_rdata;

  logic accept;
  logic rate_in_range;
  logic last_cmp;
  logic finish;

  assign in_ready      = (state == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign rate_in_range = 32'(in_server) < NUM_SERVERS;
  assign last_cmp      = CNT_W'(cmp_idx) == (live - CNT_W'(1));
  assign finish        = (state == ST_DONE) && res_ready;

  // saturating add: carry out means the sum passed the all-ones value
  assign sum_wide      = {1'b0, best_val} + (TIME_BITS + 1)'(prod);
  assign max_busy_next = (sum > max_busy) ? sum : max_busy;

  // table ports
  assign busy_we    = (state == ST_CLEAR) || finish;
  assign busy_waddr = (state == ST_CLEAR) ? clr_cnt : best;
  assign busy_wdata = (state == ST_CLEAR) ? '0 : sum;
  assign busy_raddr = (state == ST_SCAN) ? iss[SIDX_W-1:0] : '0;

  assign rate_we    = (state == ST_CLEAR) ||
                      (accept && (in_action == ACTION_SET_RATE) && rate_in_range);
  assign rate_waddr = (state == ST_CLEAR) ? clr_cnt : SIDX_W'(in_server);
  assign rate_wdata = (state == ST_CLEAR) ? UNIT_W'(1) : in_unit;

  assign res_valid          = (state == ST_DONE);
  assign res.chosen_server  = SRV_W'(best);
  assign res.finish_time    = OUT_T_W'(sum);
  assign res.makespan       = OUT_T_W'(max_busy_next);
  assign res.saturated      = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      max_busy <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + SIDX_W'(1);
          if (clr_cnt == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (in_action == ACTION_ASSIGN)) begin
            units   <= in_units;
            iss     <= CNT_W'(1);
            cmp_idx <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // rdata holds busy_time[cmp_idx]; strict less keeps the lowest index
          if ((cmp_idx == '0) || (busy_rdata < best_val)) begin
            best     <= cmp_idx;
            best_val <= busy_rdata;
          end
          cmp_idx <= iss[SIDX_W-1:0];
          iss     <= iss + CNT_W'(1);
          if (last_cmp) begin
            state <= ST_RATE;
          end
        end
        ST_RATE: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= PROD_W'(units) * PROD_W'(rate_rdata);
          state <= ST_ADD;
        end
        ST_ADD: begin
          sat   <= sum_wide[TIME_BITS];
          sum   <= sum_wide[TIME_BITS] ? '1 : sum_wide[TIME_BITS-1:0];
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            max_busy <= max_busy_next;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  lld_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (NUM_SERVERS)
  ) u_busy_ram (
    .clk   (clk),
    .we    (busy_we),
    .waddr (busy_waddr),
    .wdata (busy_wdata),
    .raddr (busy_raddr),
    .rdata (busy_rdata)
  );

  lld_ram #(
    .WIDTH (UNIT_W),
    .DEPTH (NUM_SERVERS)
  ) u_rate_ram (
    .clk   (clk),
    .we    (rate_we),
    .waddr (rate_waddr),
    .wdata (rate_wdata),
    .raddr (best),
    .rdata (rate_rdata)
  );

endmodule

FILE: design/least_loaded_job_dispatcher_top.sv
// ----------------------------------------------------------------------------
// least_loaded_job_dispatcher_top - greedy least-loaded job dispatcher
// Keeps per-server rate and busy time; an assign goes to the least-loaded
// active server and reports server, finish time and makespan.
// ----------------------------------------------------------------------------
//
//  channel   | direction | tdata (low bit up)                        | tuser
//  ----------+-----------+-------------------------------------------+-----------
//  s_axis    | in        | server_index[3:0] unit_time[11:4]         | action
//            |           | job_units[19:12], zero pad [23:20]        |
//  m_axis    | out       | chosen_server[3:0] finish_time[43:4]      | saturated
//            |           | makespan[83:44], zero pad [87:84]         |
//  cfg       | in        | cfg_wdata = active_servers, write on cfg_we | -
//
//  Sequence: a set_rate item is written to the rate table as it is taken. An
//  assign item scans n = clamped active_servers busy-time entries, one at a
//  time through the single read port of the busy-time RAM and the shared
//  compare, then rate read, multiply, saturating add and write-back.
//  Reset: a clearing pass over all NUM_SERVERS entries fills rates with one and
//  busy times with zero; no item is taken meanwhile, config writes are.
//  Stalls: the result sits in an output register; the next item is taken
//  while it waits, but the following result holds until it is taken.
//
module least_loaded_job_dispatcher_top #(
  parameter int NUM_SERVERS = lld_pkg::NUM_SERVERS_DEF,
  parameter int TIME_BITS   = lld_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // server_index, unit_time, job_units
  input  logic [0:0]                  s_axis_tuser,  // action
  // result items
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [87:0]                 m_axis_tdata,  // chosen_server, finish_time, makespan
  output logic [0:0]                  m_axis_tuser,  // saturated
  // active_servers register
  input  logic                        cfg_we,
  input  logic [lld_pkg::ACT_W-1:0]   cfg_wdata
);
  import lld_pkg::*;

  localparam int CNT_W = $clog2(NUM_SERVERS + 1);

  logic [ACT_W-1:0] active_servers;
  logic [CNT_W-1:0] live;

  logic             res_valid;
  logic             res_ready;
  lld_result_t      res;

  logic             out_valid;
  lld_result_t      out_res;

  // config register, written whenever cfg_we is high outside reset
  always_ff @(posedge clk) begin
    if (rst) begin
      active_servers <= ACT_RESET;
    end else if (cfg_we) begin
      active_servers <= cfg_wdata;
    end
  end

  // zero acts as one, anything above the server count as the full count
  always_comb begin
    if (active_servers == '0) begin
      live = CNT_W'(1);
    end else if (32'(active_servers) > NUM_SERVERS) begin
      live = CNT_W'(NUM_SERVERS);
    end else begin
      live = CNT_W'(active_servers);
    end
  end

  lld_ctrl #(
    .NUM_SERVERS (NUM_SERVERS),
    .TIME_BITS   (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser[0]),
    .in_server (s_axis_tdata[3:0]),
    .in_unit   (s_axis_tdata[11:4]),
    .in_units  (s_axis_tdata[19:12]),
    .live      (live),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_res.makespan, out_res.finish_time,
                          out_res.chosen_server};
  assign m_axis_tuser  = out_res.saturated;

endmodule

FILE: design/lld_checker.sv
// ----------------------------------------------------------------------------
// lld_checker - port-level assertions for the dispatcher
// Watches the top-level ports; attached by the bind at the end of the file.
// ----------------------------------------------------------------------------
module lld_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);
  import lld_pkg::*;

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // an assign keeps the input closed while the scan runs
  a_assign_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == ACTION_ASSIGN)
      |=> !s_axis_tready)
    else $error("input open during scan");

  // the finish time never exceeds the makespan
  a_finish_le_span: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[43:4] <= m_axis_tdata[83:44]))
    else $error("finish time above makespan");

endmodule

bind least_loaded_job_dispatcher_top lld_checker u_lld_checker (.*);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the least-loaded job dispatcher
// Drives rate writes and job assigns over the input stream. A local copy of
// the rate table, busy times and makespan predicts each result, and results
// are checked field by field in order. Idling on both sides is random, and
// one phase runs without any. The active-server register is rewritten
// between phases, including its clamped extremes.
// ----------------------------------------------------------------------------
module tb;
  import lld_pkg::*;

  localparam int SERVERS   = NUM_SERVERS_DEF;
  localparam int DRAIN_CYC = 32;          // beyond the full run of one assign
  localparam int IDLE_PCT  = 28;
  localparam int MAX_SHOWN = 10;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;   // server_index, unit_time, job_units
  logic [0:0]           s_axis_tuser;   // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [87:0]          m_axis_tdata;   // chosen_server, finish_time, makespan
  logic [0:0]           m_axis_tuser;   // saturated
  logic                 cfg_we;
  logic [ACT_W-1:0]     cfg_wdata;

  // local copy of the block's state
  bit [UNIT_W-1:0]      rate_of [SERVERS];
  bit [OUT_T_W-1:0]     busy_of [SERVERS];
  bit [OUT_T_W-1:0]     span_now;
  bit [ACT_W-1:0]       active_now;

  lld_result_t          pending_jobs[$];  // predicted dispatch results, oldest first
  int                   mismatches;
  bit                   calm;             // no idling on either side while set

  least_loaded_job_dispatcher_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // greedy pick: lowest busy time among the live servers, lowest index on a tie;
  // the sum is one bit wider so a carry out marks saturation
  function automatic lld_result_t dispatch_job(input bit [UNIT_W-1:0] units);
    int          live;
    int          best;
    bit [OUT_T_W:0] sum;
    lld_result_t res;
    live = (active_now == 0) ? 1 : (active_now > SERVERS) ? SERVERS : int'(active_now);
    best = 0;
    for (int k = 1; k < live; k++) begin
      if (busy_of[k] < busy_of[best]) best = k;
    end
    sum = {1'b0, busy_of[best]} + (OUT_T_W+1)'(units) * (OUT_T_W+1)'(rate_of[best]);
    res.saturated = sum[OUT_T_W];
    busy_of[best] = sum[OUT_T_W] ? '1 : sum[OUT_T_W-1:0];
    if (busy_of[best] > span_now) span_now = busy_of[best];
    res.chosen_server = SRV_W'(best);
    res.finish_time   = busy_of[best];
    res.makespan      = span_now;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // one item; valid stays high on return so back-to-back items need no toggle
  task automatic send_item(input logic act, input bit [SRV_W-1:0] srv,
                           input bit [UNIT_W-1:0] unit_t, input bit [UNIT_W-1:0] job_u);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0, job_u, unit_t, srv};
    do @(posedge clk); while (!s_axis_tready);
    if (act == ACTION_SET_RATE)
      rate_of[srv] = unit_t;
    else
      pending_jobs.push_back(dispatch_job(job_u));
  endtask

  task automatic assign_job(input bit [UNIT_W-1:0] job_u);
    send_item(ACTION_ASSIGN, SRV_W'($urandom), UNIT_W'($urandom), job_u);
  endtask

  task automatic set_rate(input bit [SRV_W-1:0] srv, input bit [UNIT_W-1:0] unit_t);
    send_item(ACTION_SET_RATE, srv, unit_t, UNIT_W'($urandom));
  endtask

  // register write only once the block has gone quiet; a trailing rate write
  // gives no result, so allow a full assign time after the last result too
  task automatic write_active(input bit [ACT_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_jobs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    active_now = val;
  endtask

  function automatic bit [ACT_W-1:0] ACT_WIDTH_RAND(input int lo, input int hi);
    return ACT_W'($urandom_range(hi, lo));
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset state: all rates one, all loads zero, so ties walk up from server 0
  task automatic test_reset_state();
    for (int k = 0; k < 4; k++) assign_job(8'd1);
  endtask

  // field extremes, zero rate, zero job and the clamped register values
  task automatic test_extremes();
    set_rate(4'd0, 8'd255);
    set_rate(4'd15, 8'd0);
    set_rate(4'd7, 8'd1);
    write_active(5'd1);             // only server 0 live
    assign_job(8'd255);
    assign_job(8'd0);               // zero job still gives a result
    write_active(5'd0);             // zero acts as one
    assign_job(8'd255);
    write_active(5'd31);            // above the server count acts as all
    for (int k = 0; k < 6; k++) assign_job(8'd255);
    set_rate(4'd4, 8'd0);
    assign_job(8'd200);             // server 4 now has rate zero; this job goes to server 10
    write_active(5'd17);
    assign_job(8'd128);
    assign_job(8'd1);
    write_active(5'd16);
    set_rate(4'd15, 8'd255);
    assign_job(8'd127);
  endtask

  // long random run, one register setting per phase; mostly assigns
  task automatic test_random_mix();
    bit [ACT_W-1:0] setting [10];
    setting = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd8, 5'd17, 5'd5, 5'd12, 5'd16};
    setting[4] = ACT_WIDTH_RAND(2, 15);
    setting[6] = ACT_WIDTH_RAND(17, 30);
    for (int p = 0; p < 10; p++) begin
      write_active(setting[p]);
      calm = (p == 5);              // one phase with no gaps at all
      for (int i = 0; i < 135; i++) begin
        if ($urandom_range(99) < 22)
          set_rate(SRV_W'($urandom), ($urandom_range(19) == 0) ? 8'd0 : UNIT_W'($urandom));
        else if ($urandom_range(19) == 0)
          assign_job($urandom_range(1) ? 8'd0 : 8'd255);
        else
          assign_job(UNIT_W'($urandom));
      end
      calm = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random back-pressure and the in-order check
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic void note_mismatch(input string what, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    lld_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_jobs.size() == 0) begin
        note_mismatch("unexpected result, server", 0, m_axis_tdata[3:0]);
      end else begin
        want = pending_jobs.pop_front();
        if (m_axis_tdata[3:0] !== want.chosen_server)
          note_mismatch("chosen_server", want.chosen_server, m_axis_tdata[3:0]);
        if (m_axis_tdata[43:4] !== want.finish_time)
          note_mismatch("finish_time", want.finish_time, m_axis_tdata[43:4]);
        if (m_axis_tdata[83:44] !== want.makespan)
          note_mismatch("makespan", want.makespan, m_axis_tdata[83:44]);
        if (m_axis_tuser[0] !== want.saturated)
          note_mismatch("saturated", want.saturated, m_axis_tuser[0]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    mismatches    = 0;
    calm          = 1'b0;
    for (int k = 0; k < SERVERS; k++) begin
      rate_of[k] = 8'd1;
      busy_of[k] = '0;
    end
    span_now   = '0;
    active_now = ACT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_extremes();
    test_random_mix();

    // drain: every result in, then quiet time for any stray output
    s_axis_tvalid <= 1'b0;
    while (pending_jobs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: least_loaded_job_dispatcher_top.f
design/lld_pkg.sv
design/lld_ram.sv
design/lld_ctrl.sv
design/least_loaded_job_dispatcher_top.sv
design/lld_checker.sv
dv/tb.sv
